>>> design/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants for the record frame checker with CRC-32.
// ----------------------------------------------------------------------------
package rfc_pkg;

  // record layout
  localparam int unsigned RECORD_LENGTH = 14;
  localparam int unsigned CRC_END       = 10;
  localparam logic [3:0]  POS_VERSION   = 4'd4;
  localparam logic [3:0]  POS_STATUS    = 4'd5;
  localparam logic [3:0]  POS_LAST      = 4'(RECORD_LENGTH - 1);
  localparam logic [3:0]  POS_CRC_END   = 4'(CRC_END);
  localparam logic [3:0]  COUNT_MAX     = 4'd15;

  // reflected crc-32 (ieee)
  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  // magic bytes at offsets 0..3
  localparam logic [7:0] MAGIC [4] = '{8'h4c, 8'h4f, 8'h41, 8'h31};

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PROTOCOL_VERSION = 2'd0,
    CFG_STATUS_COUNT     = 2'd1,
    CFG_OFF_STATUS       = 2'd2
  } cfg_index_t;

  // result error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FORMAT = 2'd1,
    ERR_CRC    = 2'd2,
    ERR_STATUS = 2'd3
  } err_t;

endpackage

>>> design/rfc_byte_if.sv
// ----------------------------------------------------------------------------
// rfc_byte_if
// Byte channel into the checker: valid/ready with record byte and last mark.
// ----------------------------------------------------------------------------
interface rfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       last_byte;

  modport source (output valid, output record_byte, output last_byte, input ready);
  modport sink   (input valid, input record_byte, input last_byte, output ready);
endinterface

>>> design/rfc_result_if.sv
// ----------------------------------------------------------------------------
// rfc_result_if
// Result channel out of the checker: valid/ready with the decoded record.
// ----------------------------------------------------------------------------
interface rfc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  error_code;
  logic [7:0]  message_status;
  logic [31:0] record_id;
  logic        decode_ok;

  modport source (output valid, output error_code, output message_status,
                  output record_id, output decode_ok, input ready);
  modport sink   (input valid, input error_code, input message_status,
                  input record_id, input decode_ok, output ready);
endinterface

>>> design/record_frame_checker_crc32.sv
// ----------------------------------------------------------------------------
// record_frame_checker_crc32
// Checks 14-byte records: magic, version, CRC-32 over bytes 0-9 against the
// little-endian CRC in bytes 10-13, and status range; gives one result per
// record on its last byte.
//
//   channel  dir  handshake      payload
//   rx       in   valid/ready    record_byte[7:0], last_byte
//   res      out  valid/ready    error_code[1:0], message_status[7:0],
//                                record_id[31:0], decode_ok
//   cfg      in   cfg_we         cfg_index[1:0], cfg_data[7:0]
//
// One byte per cycle when rx is ready: each accepted byte updates the record
// registers through a single byte-wide CRC step, and the last byte loads the
// result register, so a result appears the cycle after its last byte transfer.
// The result register parts the two sides: rx stays ready while it is empty
// or being drained, so bytes keep flowing back to back when res.ready is high.
// Synchronous reset returns record state and all registers but the result
// payload to their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module record_frame_checker_crc32 (
  input  logic                clk,
  input  logic                rst,
  rfc_byte_if.sink            rx,
  rfc_result_if.source        res,
  input  logic                cfg_we,
  input  rfc_pkg::cfg_index_t cfg_index,
  input  logic [7:0]          cfg_data
);
  import rfc_pkg::*;

  // configuration registers
  logic [7:0] protocol_version;
  logic [7:0] status_count;
  logic [7:0] off_status;

  // record state
  logic [3:0]  byte_count;
  logic [31:0] crc_accum;
  logic        header_good;
  logic [7:0]  status_hold;
  logic [31:0] id_hold;
  logic [31:0] received_crc;

  logic [3:0]  byte_count_next;
  logic [31:0] crc_accum_next;
  logic        header_good_next;
  logic [7:0]  status_hold_next;
  logic [31:0] id_hold_next;
  logic [31:0] received_crc_next;

  logic [31:0] crc_step;
  logic        accept;
  err_t        code;

  assign rx.ready = !res.valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= 8'd1;
      status_count     <= 8'd3;
      off_status       <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROTOCOL_VERSION: protocol_version <= cfg_data;
        CFG_STATUS_COUNT:     status_count     <= cfg_data;
        CFG_OFF_STATUS:       off_status       <= cfg_data;
        default: ;
      endcase
    end
  end

  rfc_crc_byte u_crc (
    .crc      (crc_accum),
    .data     (rx.record_byte),
    .crc_next (crc_step)
  );

  // per-byte field capture and header check
  always_comb begin
    header_good_next  = header_good;
    status_hold_next  = status_hold;
    id_hold_next      = id_hold;
    received_crc_next = received_crc;
    if (byte_count < POS_VERSION) begin
      if (rx.record_byte != MAGIC[byte_count[1:0]]) header_good_next = 1'b0;
    end
    unique case (byte_count)
      4'd4:    if (rx.record_byte != protocol_version) header_good_next = 1'b0;
      4'd5:    status_hold_next         = rx.record_byte;
      4'd6:    id_hold_next[7:0]        = rx.record_byte;
      4'd7:    id_hold_next[15:8]       = rx.record_byte;
      4'd8:    id_hold_next[23:16]      = rx.record_byte;
      4'd9:    id_hold_next[31:24]      = rx.record_byte;
      4'd10:   received_crc_next[7:0]   = rx.record_byte;
      4'd11:   received_crc_next[15:8]  = rx.record_byte;
      4'd12:   received_crc_next[23:16] = rx.record_byte;
      4'd13:   received_crc_next[31:24] = rx.record_byte;
      default: ;
    endcase
    crc_accum_next  = (byte_count < POS_CRC_END) ? crc_step : crc_accum;
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 4'd1 : byte_count;
  end

  // verdict on the last byte, in precedence order
  always_comb begin
    priority if (byte_count != POS_LAST || !header_good_next) code = ERR_FORMAT;
    else if (~crc_accum_next != received_crc_next)            code = ERR_CRC;
    else if (status_hold_next >= status_count)                code = ERR_STATUS;
    else                                                      code = ERR_NONE;
  end

  // record state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && rx.last_byte)) begin
      byte_count   <= 4'd0;
      crc_accum    <= CRC_INIT;
      header_good  <= 1'b1;
      status_hold  <= 8'd0;
      id_hold      <= 32'd0;
      received_crc <= 32'd0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      crc_accum    <= crc_accum_next;
      header_good  <= header_good_next;
      status_hold  <= status_hold_next;
      id_hold      <= id_hold_next;
      received_crc <= received_crc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept && rx.last_byte) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx.last_byte) begin
      res.error_code <= code;
      if (code == ERR_NONE) begin
        res.message_status <= status_hold_next;
        res.record_id      <= id_hold_next;
        res.decode_ok      <= 1'b1;
      end else begin
        res.message_status <= off_status;
        res.record_id      <= 32'd0;
        res.decode_ok      <= 1'b0;
      end
    end
  end

  // checks
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.decode_ok == (res.error_code == ERR_NONE)))
    else $error("decode_ok disagrees with error_code");

  a_failed_id_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.decode_ok |-> res.record_id == 32'd0)
    else $error("failed record carries a nonzero id");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && rx.last_byte |=> byte_count == 4'd0 && header_good)
    else $error("record state not cleared after last byte");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    accept && !rx.last_byte && byte_count < COUNT_MAX
      |=> byte_count == $past(byte_count) + 4'd1)
    else $error("byte count did not advance");

endmodule

>>> design/rfc_crc_byte.sv
// ----------------------------------------------------------------------------
// rfc_crc_byte
// One-byte update of a reflected CRC-32, eight shift/xor steps in logic.
// ----------------------------------------------------------------------------
module rfc_crc_byte (
  input  logic [31:0] crc,
  input  logic [7:0]  data,
  output logic [31:0] crc_next
);
  import rfc_pkg::*;

  // bitwise lsb-first division by the reflected polynomial
  always_comb begin
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_next = c;
  end

endmodule

>>> tb/tb_record_frame_checker_crc32.sv
// ----------------------------------------------------------------------------
// tb_record_frame_checker_crc32
// Self-checking bench for the record frame checker. Records are streamed
// byte by byte over the rx channel and a local model of the checker works
// out the result of every record: header, CRC-32, status and length checks.
// Each result on the res channel is compared against the oldest prediction.
// Directed records cover the error cases and register extremes; random
// phases mix well-formed records with corrupted, truncated, overlong and
// noise records under random register settings, with random stalls in most.
// ----------------------------------------------------------------------------
module tb_record_frame_checker_crc32;
  import rfc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_BYTES  = 400;

  typedef struct packed {
    err_t        code;
    logic [7:0]  status;
    logic [31:0] id;
    logic        ok;
  } frame_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic [7:0] cfg_data;

  rfc_byte_if   rx_if ();
  rfc_result_if res_if ();

  record_frame_checker_crc32 uut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies held by the model
  logic [7:0] cfg_version;
  logic [7:0] cfg_status_count;
  logic [7:0] cfg_off_status;

  // record state held by the model
  logic [3:0]  frm_count;
  logic [31:0] frm_crc;
  logic        frm_header_ok;
  logic [7:0]  frm_status;
  logic [31:0] frm_id;
  logic [31:0] frm_rx_crc;

  frame_result_t pending_results[$];
  logic [7:0]    frame_buf[$];

  frame_result_t want_result;
  frame_result_t seen_result;

  bit idle_on;
  int stall_left;
  int quiet_cycles;
  int mismatches;
  int bytes_sent;
  int results_seen;
  int cfg_settings;
  int code_seen[4];

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model of the checker
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    frm_count     = '0;
    frm_crc       = CRC_INIT;
    frm_header_ok = 1'b1;
    frm_status    = '0;
    frm_id        = '0;
    frm_rx_crc    = '0;
  endfunction

  // advance the model by one accepted byte, queue a result on the last one
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [3:0]    pos;
    frame_result_t r;
    pos = frm_count;
    if (pos < 4) begin
      if (b != MAGIC[pos[1:0]]) frm_header_ok = 1'b0;
    end else if (pos == POS_VERSION) begin
      if (b != cfg_version) frm_header_ok = 1'b0;
    end else if (pos == POS_STATUS) begin
      frm_status = b;
    end else if (pos < POS_CRC_END) begin
      frm_id = frm_id | ({24'h0, b} << (8 * (int'(pos) - 6)));
    end else if (pos <= POS_LAST) begin
      frm_rx_crc = frm_rx_crc | ({24'h0, b} << (8 * (int'(pos) - int'(POS_CRC_END))));
    end
    if (pos < POS_CRC_END) frm_crc = crc32_update(frm_crc, b);
    if (frm_count != COUNT_MAX) frm_count = frm_count + 4'd1;

    if (last) begin
      if (pos != POS_LAST || !frm_header_ok) r.code = ERR_FORMAT;
      else if (~frm_crc != frm_rx_crc)      r.code = ERR_CRC;
      else if (frm_status >= cfg_status_count) r.code = ERR_STATUS;
      else                                   r.code = ERR_NONE;
      if (r.code == ERR_NONE) begin
        r.status = frm_status;
        r.id     = frm_id;
        r.ok     = 1'b1;
      end else begin
        r.status = cfg_off_status;
        r.id     = '0;
        r.ok     = 1'b0;
      end
      pending_results.push_back(r);
      clear_frame();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // record builders
  // ---------------------------------------------------------------------------

  // bytes 0-9: magic, version, status, id
  task automatic build_body(input logic [7:0] ver, input logic [7:0] st, input logic [31:0] id);
    frame_buf.delete();
    for (int i = 0; i < 4; i++) frame_buf.push_back(MAGIC[i]);
    frame_buf.push_back(ver);
    frame_buf.push_back(st);
    for (int i = 0; i < 4; i++) frame_buf.push_back(id[8*i +: 8]);
  endtask

  // append the little-endian crc of bytes 0-9
  task automatic seal_frame();
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < int'(CRC_END); i++) c = crc32_update(c, frame_buf[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) frame_buf.push_back(c[8*i +: 8]);
  endtask

  task automatic build_frame(input logic [7:0] ver, input logic [7:0] st, input logic [31:0] id);
    build_body(ver, st, id);
    seal_frame();
  endtask

  function automatic logic [7:0] pick_status();
    if (cfg_status_count != 0 && $urandom_range(0, 3) != 0)
      return 8'($urandom_range(0, int'(cfg_status_count) - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one byte transfer on rx, with an optional idle gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    rx_if.valid       = 1'b1;
    rx_if.record_byte = b;
    rx_if.last_byte   = last;
    do @(posedge clk); while (!rx_if.ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // close any open record, stop sending and let every result come out
  task automatic drain_block();
    if (frm_count != 0) send_byte(8'h00, 1'b1);
    @(negedge clk);
    rx_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    case (idx)
      CFG_PROTOCOL_VERSION: cfg_version      = value;
      CFG_STATUS_COUNT:     cfg_status_count = value;
      CFG_OFF_STATUS:       cfg_off_status   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] ver, input logic [7:0] count, input logic [7:0] off);
    write_register(CFG_PROTOCOL_VERSION, ver);
    write_register(CFG_STATUS_COUNT, count);
    write_register(CFG_OFF_STATUS, off);
    cfg_settings++;
  endtask

  // result side: random stall bursts when idle_on is set, with ready between them
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      res_if.ready = 1'b0;
    end else if (idle_on && res_if.ready && $urandom_range(0, 5) == 0) begin
      stall_left   = $urandom_range(1, 12) - 1;
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      seen_result.code   = err_t'(res_if.error_code);
      seen_result.status = res_if.message_status;
      seen_result.id     = res_if.record_id;
      seen_result.ok     = res_if.decode_ok;
      results_seen++;
      code_seen[res_if.error_code]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: err=%0d status=%02h id=%08h ok=%0b",
                   seen_result.code, seen_result.status, seen_result.id, seen_result.ok);
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.code !== want_result.code || seen_result.status !== want_result.status ||
            seen_result.id !== want_result.id || seen_result.ok !== want_result.ok) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected err=%0d status=%02h id=%08h ok=%0b",
                     want_result.code, want_result.status, want_result.id, want_result.ok);
            $display("                 got      err=%0d status=%02h id=%08h ok=%0b",
                     seen_result.code, seen_result.status, seen_result.id, seen_result.ok);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values, error cases and their precedence
  task automatic test_default_records();
    idle_on = 1'b1;
    build_frame(8'd1, 8'd0, 32'h0000_0000);
    send_frame();
    build_frame(8'd1, 8'd2, 32'hffff_ffff);
    send_frame();
    // status out of range
    build_frame(8'd1, 8'd3, 32'h0102_0304);
    send_frame();
    // crc mismatch in the last byte
    build_frame(8'd1, 8'd1, 32'hdead_beef);
    frame_buf[13] ^= 8'h80;
    send_frame();
    // crc error wins over a bad status
    build_frame(8'd1, 8'd200, 32'h5555_aaaa);
    frame_buf[10] ^= 8'h01;
    send_frame();
    // bad magic with a matching crc, first and last magic byte
    build_body(8'd1, 8'd0, 32'h1111_2222);
    frame_buf[0] = 8'h00;
    seal_frame();
    send_frame();
    build_body(8'd1, 8'd0, 32'h3333_4444);
    frame_buf[3] = 8'hff;
    seal_frame();
    send_frame();
    // wrong version
    build_frame(8'd2, 8'd0, 32'h0000_0001);
    send_frame();
    // header error wins over a crc error
    build_frame(8'd1, 8'd0, 32'h8000_0000);
    frame_buf[1] ^= 8'h40;
    frame_buf[12] ^= 8'h10;
    send_frame();
    // too short: a lone last byte, then thirteen bytes
    send_byte(8'h4c, 1'b1);
    build_frame(8'd1, 8'd0, 32'h7777_7777);
    void'(frame_buf.pop_back());
    send_frame();
    // too long: fifteen bytes, then twenty so the count saturates
    build_frame(8'd1, 8'd0, 32'h0f0f_0f0f);
    frame_buf.push_back(8'hff);
    send_frame();
    build_frame(8'd1, 8'd0, 32'hf0f0_f0f0);
    repeat (6) frame_buf.push_back(8'h00);
    send_frame();
    // a clean record right after the errors
    build_frame(8'd1, 8'd1, 32'h1234_5678);
    send_frame();
    drain_block();
  endtask

  // register extremes, including a zero status count
  task automatic test_register_extremes();
    set_config(8'd0, 8'd255, 8'd255);
    build_frame(8'd0, 8'd254, $urandom());
    send_frame();
    build_frame(8'd0, 8'd255, $urandom());
    send_frame();
    build_frame(8'd1, 8'd0, $urandom());
    send_frame();
    drain_block();

    set_config(8'd255, 8'd1, 8'ha5);
    build_frame(8'd255, 8'd0, $urandom());
    send_frame();
    build_frame(8'd255, 8'd1, $urandom());
    send_frame();
    build_frame(8'd255, 8'd0, $urandom());
    repeat (3) void'(frame_buf.pop_back());
    send_frame();
    drain_block();

    set_config(8'd1, 8'd0, 8'h5a);
    build_frame(8'd1, 8'd0, $urandom());
    send_frame();
    build_frame(8'd1, 8'd0, $urandom());
    frame_buf[11] ^= 8'h04;
    send_frame();
    drain_block();
  endtask

  // mostly well-formed records, with corrupted and malformed ones mixed in
  task automatic test_random_traffic(input int target, input bit with_idle);
    int          start;
    int          kind;
    int          n;
    logic [7:0]  ver;
    logic [7:0]  count;
    ver   = 8'($urandom_range(0, 255));
    count = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    set_config(ver, count, 8'($urandom_range(0, 255)));
    idle_on = with_idle;
    start   = bytes_sent;
    while (bytes_sent - start < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 84) build_frame(cfg_version, pick_status(), $urandom());
      if (kind >= 60 && kind < 70) begin
        // single bit flip anywhere in the record
        n = $urandom_range(0, 13);
        frame_buf[n] ^= 8'(1 << $urandom_range(0, 7));
      end else if (kind >= 70 && kind < 77) begin
        // truncated record
        n = $urandom_range(1, 13);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
      end else if (kind >= 77 && kind < 84) begin
        // overlong record
        repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom()));
      end else if (kind >= 84 && kind < 90) begin
        // bad magic or version behind a valid crc
        build_body(cfg_version, pick_status(), $urandom());
        n = $urandom_range(0, 4);
        frame_buf[n] ^= 8'($urandom_range(1, 255));
        seal_frame();
      end else if (kind >= 90) begin
        // random noise of random length
        frame_buf.delete();
        repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom()));
      end
      send_frame();
    end
    drain_block();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PROTOCOL_VERSION;
    cfg_data          = 8'h00;
    rx_if.valid       = 1'b0;
    rx_if.record_byte = 8'h00;
    rx_if.last_byte   = 1'b0;
    res_if.ready      = 1'b0;
    idle_on           = 1'b0;
    stall_left        = 0;
    quiet_cycles      = 0;
    mismatches        = 0;
    bytes_sent        = 0;
    results_seen      = 0;
    cfg_settings      = 1;
    for (int i = 0; i < 4; i++) code_seen[i] = 0;
    cfg_version      = 8'd1;
    cfg_status_count = 8'd3;
    cfg_off_status   = 8'd0;
    clear_frame();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_records();
    test_register_extremes();
    test_random_traffic(PHASE_BYTES, 1'b1);
    test_random_traffic(PHASE_BYTES, 1'b1);
    test_random_traffic(PHASE_BYTES, 1'b1);
    test_random_traffic(PHASE_BYTES, 1'b0);

    if (pending_results.size() != 0) mismatches++;
    $display("sent %0d bytes, checked %0d records under %0d register settings",
             bytes_sent, results_seen, cfg_settings);
    $display("records by outcome: %0d accepted, %0d format, %0d crc, %0d status errors",
             code_seen[ERR_NONE], code_seen[ERR_FORMAT], code_seen[ERR_CRC],
             code_seen[ERR_STATUS]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
